FILE: design/strided_tensor_walker_macros.svh
// Assertion macros shared by the strided tensor walker modules.
`ifndef STRIDED_TENSOR_WALKER_MACROS_SVH
`define STRIDED_TENSOR_WALKER_MACROS_SVH

// Flag any clock edge outside reset at which cond is false.
`define STW_ASSERT_ALWAYS(lbl, clk_s, rst_s, cond, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (cond)) \
        else $error(msg);

// Flag an edge at which ante holds and cons fails at the next edge.
`define STW_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/stw_pkg.sv
// Shared types, constants and helper functions of the strided tensor walker.
`timescale 1ns / 1ps

package stw_pkg;

    localparam int MAX_DIMS    = 4;
    localparam int EXTENT_BITS = 12;

    localparam int DIMS_W     = 3;
    localparam int EXTENTS_W  = 48;
    localparam int STRIDES_W  = 63;
    localparam int STRIDE_W   = 32;
    localparam int OFFSET_W   = 32;
    localparam int MODE_W     = 2;
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = 46;
    localparam int COUNT_W    = 48;
    localparam int CFG_DATA_W = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int PROD_W     = EXTENT_BITS + STRIDE_W;

    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic [EXTENTS_W-1:0] EXTENTS_RESET = 48'h0010_0100_1001;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DIM_COUNT    = 3'd0,
        REG_EXTENTS      = 3'd1,
        REG_STRIDES_LOW  = 3'd2,
        REG_STRIDES_HIGH = 3'd3,
        REG_BASE_OFFSET  = 3'd4,
        REG_WALK_MODE    = 3'd5,
        REG_FILL_VALUE   = 3'd6
    } cfg_reg_e;

    typedef enum logic [MODE_W-1:0] {
        MODE_GATHER  = 2'd0,
        MODE_SCATTER = 2'd1,
        MODE_FILL    = 2'd2
    } walk_mode_e;

    typedef struct packed {
        logic [DIMS_W-1:0]    dim_count;
        logic [EXTENTS_W-1:0] extents;
        logic [STRIDES_W-1:0] strides_low;
        logic [STRIDES_W-1:0] strides_high;
        logic [OFFSET_W-1:0]  base_offset;
        logic [MODE_W-1:0]    walk_mode;
        logic [WORD_W-1:0]    fill_value;
    } cfg_t;

    // One classified step handed from the counter front to the address back.
    typedef struct packed {
        logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] idx;
        logic [COUNT_W-1:0]                   count;
        logic [WORD_W-1:0]                    data;
        logic                                 last;
    } walk_item_t;

    // Extent of dim d; a zero field or a field beyond the register reads as one.
    function automatic logic [EXTENT_BITS-1:0] extent_of(
        input logic [EXTENTS_W-1:0] ext,
        input int                   d
    );
        logic [EXTENTS_W-1:0]   sh;
        logic [EXTENT_BITS-1:0] e;
        sh = ext >> (d * EXTENT_BITS);
        e  = sh[EXTENT_BITS-1:0];
        if (d * EXTENT_BITS >= EXTENTS_W || e == '0)
        begin
            e = EXTENT_BITS'(1);
        end
        return e;
    endfunction

    // Stride of dim d; dims above the fourth have none.
    function automatic logic [STRIDE_W-1:0] stride_of(
        input logic [STRIDES_W-1:0] lo,
        input logic [STRIDES_W-1:0] hi,
        input int                   d
    );
        logic [STRIDE_W-1:0] s;
        unique case (d)
            0:       s = lo[STRIDE_W-1:0];
            1:       s = {1'b0, lo[STRIDES_W-1:STRIDE_W]};
            2:       s = hi[STRIDE_W-1:0];
            3:       s = {1'b0, hi[STRIDES_W-1:STRIDE_W]};
            default: s = '0;
        endcase
        return s;
    endfunction

endpackage

FILE: design/stw_cfg.sv
// Configuration register file of the strided tensor walker.
`timescale 1ns / 1ps

module stw_cfg
    import stw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DIM_COUNT:    cfg_next.dim_count    = cfg_data[DIMS_W-1:0];
                REG_EXTENTS:      cfg_next.extents      = cfg_data[EXTENTS_W-1:0];
                REG_STRIDES_LOW:  cfg_next.strides_low  = cfg_data[STRIDES_W-1:0];
                REG_STRIDES_HIGH: cfg_next.strides_high = cfg_data[STRIDES_W-1:0];
                REG_BASE_OFFSET:  cfg_next.base_offset  = cfg_data[OFFSET_W-1:0];
                REG_WALK_MODE:    cfg_next.walk_mode    = cfg_data[MODE_W-1:0];
                REG_FILL_VALUE:   cfg_next.fill_value   = cfg_data[WORD_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dim_count    <= DIMS_W'(1);
            cfg_reg.extents      <= EXTENTS_RESET;
            cfg_reg.strides_low  <= '0;
            cfg_reg.strides_high <= '0;
            cfg_reg.base_offset  <= '0;
            cfg_reg.walk_mode    <= MODE_GATHER;
            cfg_reg.fill_value   <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: design/stw_front.sv
// Walk front: per-dim index counters, element count and last detection.
`timescale 1ns / 1ps

module stw_front
    import stw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              action,
    input  logic [WORD_W-1:0] elem_value,
    output logic              item_valid,
    input  logic              item_ready,
    output walk_item_t        item
);

    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] idx_reg;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] idx_next;
    logic [COUNT_W-1:0]                   count_reg;
    logic [COUNT_W-1:0]                   count_next;

    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] idx_cur;
    logic [MAX_DIMS-1:0][EXTENT_BITS-1:0] idx_step;
    logic [MAX_DIMS-1:0]                  used;
    logic [MAX_DIMS-1:0]                  at_end;
    logic [COUNT_W-1:0]                   count_cur;
    logic                                 last;
    logic                                 take;

    assign take       = in_valid && item_ready;
    assign in_ready   = item_ready;
    assign item_valid = in_valid;

    always_comb
    begin
        int n;
        logic carry;
        logic [EXTENT_BITS:0] inc;
        logic [EXTENT_BITS:0] ext;

        n = int'(cfg.dim_count);
        if (n == 0)
        begin
            n = 1;
        end
        else if (n > MAX_DIMS)
        begin
            n = MAX_DIMS;
        end

        count_cur = action ? '0 : count_reg;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            used[d]    = (d < n);
            idx_cur[d] = action ? '0 : idx_reg[d];
            inc        = {1'b0, idx_cur[d]} + (EXTENT_BITS+1)'(1);
            ext        = {1'b0, extent_of(cfg.extents, d)};
            at_end[d]  = (inc >= ext);
        end
        last = &(at_end | ~used);

        // Ripple the carry from the innermost dim outward.
        carry = 1'b1;
        for (int d = MAX_DIMS - 1; d >= 0; d--)
        begin
            idx_step[d] = idx_cur[d];
            if (used[d] && carry)
            begin
                if (at_end[d])
                begin
                    idx_step[d] = '0;
                end
                else
                begin
                    idx_step[d] = idx_cur[d] + EXTENT_BITS'(1);
                    carry       = 1'b0;
                end
            end
        end

        for (int d = 0; d < MAX_DIMS; d++)
        begin
            item.idx[d] = used[d] ? idx_cur[d] : '0;
        end
        item.count = count_cur;
        item.data  = (cfg.walk_mode == MODE_FILL) ? cfg.fill_value : elem_value;
        item.last  = last;

        idx_next   = idx_reg;
        count_next = count_reg;
        if (take)
        begin
            if (last)
            begin
                idx_next   = '0;
                count_next = '0;
            end
            else
            begin
                idx_next   = idx_step;
                count_next = count_cur + COUNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: design/stw_queue.sv
// Short flop-based queue between the walk front and the address back.
`timescale 1ns / 1ps

`include "strided_tensor_walker_macros.svh"

module stw_queue
    import stw_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  walk_item_t in_item,
    output logic       out_valid,
    input  logic       out_ready,
    output walk_item_t out_item
);

    walk_item_t         store [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg;
    logic [Q_CNT_W-1:0] count_next;
    logic               push;
    logic               pop;

    assign in_ready  = (count_reg != Q_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + Q_PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + Q_PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            store[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `STW_ASSERT_ALWAYS(a_count_bound, clk, rst_n,
        count_reg <= Q_CNT_W'(QUEUE_DEPTH), "queue count above depth")
    `STW_ASSERT_ALWAYS(a_empty_ptrs, clk, rst_n,
        (count_reg != '0) || (wr_ptr_reg == rd_ptr_reg), "empty queue with unequal pointers")
    `STW_ASSERT_NEXT(a_count_track, clk, rst_n, push && !pop,
        count_reg == $past(count_reg) + Q_CNT_W'(1), "queue count missed a push")

endmodule

FILE: design/stw_back.sv
// Address back: strided address products, adder stage and output register.
`timescale 1ns / 1ps

module stw_back
    import stw_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cfg_t               cfg,
    input  logic               item_valid,
    output logic               item_ready,
    input  walk_item_t         item,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [ADDR_W-1:0]  strided_addr,
    output logic [COUNT_W-1:0] linear_index,
    output logic [WORD_W-1:0]  data_word,
    output logic               last
);

    localparam int HALF = (MAX_DIMS + 1) / 2;

    logic en;

    // Stage 1: one product per dim.
    logic                             s1_valid_reg;
    logic [MAX_DIMS-1:0][PROD_W-1:0]  s1_prod_reg;
    logic [MAX_DIMS-1:0][PROD_W-1:0]  s1_prod_next;
    logic [COUNT_W-1:0]               s1_count_reg;
    logic [WORD_W-1:0]                s1_data_reg;
    logic                             s1_last_reg;

    // Stage 2: two partial sums.
    logic                             s2_valid_reg;
    logic [ADDR_W-1:0]                s2_a_reg;
    logic [ADDR_W-1:0]                s2_b_reg;
    logic [ADDR_W-1:0]                s2_a_next;
    logic [ADDR_W-1:0]                s2_b_next;
    logic [COUNT_W-1:0]               s2_count_reg;
    logic [WORD_W-1:0]                s2_data_reg;
    logic                             s2_last_reg;

    // Stage 3: output register.
    logic                             out_valid_reg;
    logic [ADDR_W-1:0]                addr_reg;
    logic [ADDR_W-1:0]                addr_next;
    logic [COUNT_W-1:0]               count_reg;
    logic [WORD_W-1:0]                data_reg;
    logic                             last_reg;

    assign en         = !out_valid_reg || out_ready;
    assign item_ready = en;

    always_comb
    begin
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            s1_prod_next[d] = PROD_W'({{STRIDE_W{1'b0}}, item.idx[d]}
                                      * {{EXTENT_BITS{1'b0}},
                                         stride_of(cfg.strides_low, cfg.strides_high, d)});
        end
    end

    always_comb
    begin
        s2_a_next = '0;
        s2_b_next = ADDR_W'(cfg.base_offset);
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if (d < HALF)
            begin
                s2_a_next = s2_a_next + ADDR_W'(s1_prod_reg[d]);
            end
            else
            begin
                s2_b_next = s2_b_next + ADDR_W'(s1_prod_reg[d]);
            end
        end
        addr_next = s2_a_reg + s2_b_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_prod_reg  <= s1_prod_next;
            s1_count_reg <= item.count;
            s1_data_reg  <= item.data;
            s1_last_reg  <= item.last;
            s2_a_reg     <= s2_a_next;
            s2_b_reg     <= s2_b_next;
            s2_count_reg <= s1_count_reg;
            s2_data_reg  <= s1_data_reg;
            s2_last_reg  <= s1_last_reg;
            addr_reg     <= addr_next;
            count_reg    <= s2_count_reg;
            data_reg     <= s2_data_reg;
            last_reg     <= s2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= item_valid;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign strided_addr = addr_reg;
    assign linear_index = count_reg;
    assign data_word    = data_reg;
    assign last         = last_reg;

endmodule

FILE: design/strided_tensor_walker.sv
// Top level of the strided tensor walker address generator.
`timescale 1ns / 1ps

// Strided tensor walker: walks an N-dimensional strided view in row-major
// order (dim 0 outermost) and gives one result per step transaction: the
// strided element address (base_offset plus the sum of index times stride),
// the row-major linear index, the data word to move (fill_value in fill mode,
// else the step's element word) and tlast on the element that ends the walk,
// after which all counters return to zero. A step with tuser set restarts the
// walk and then emits the first element. The block sustains one element per
// clock while the result stream does not stall: the index counters advance in
// the front on each accepted step, and the address is formed in a three-stage
// back (per-dim multiply, partial sums, final add) behind a four-entry queue,
// so each step passes the queue and then the product, partial-sum and output
// registers in that order. Write configuration only while no step is
// in flight.
module strided_tensor_walker
    import stw_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    // Configuration write port
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // Step stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [31:0] elem_value
    input  logic                  s_tuser,   // [0] action (restart)

    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [127:0]          m_tdata,   // [45:0] strided_addr, [93:46] linear_index,
                                             // [125:94] data_word, [127:126] zero
    output logic                  m_tlast    // last element of the walk
);

    cfg_t               cfg;
    walk_item_t         front_item;
    walk_item_t         back_item;
    logic               front_valid;
    logic               front_ready;
    logic               back_valid;
    logic               back_ready;
    logic [ADDR_W-1:0]  strided_addr;
    logic [COUNT_W-1:0] linear_index;
    logic [WORD_W-1:0]  data_word;

    stw_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Front: classify each step (restart, advance, last) and update counters.
    stw_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .action     (s_tuser),
        .elem_value (s_tdata[WORD_W-1:0]),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    // Queue: let the front keep counting while the result side stalls.
    stw_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_item   (front_item),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_item  (back_item)
    );

    // Back: form the strided address and hold the result until taken.
    stw_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item_valid   (back_valid),
        .item_ready   (back_ready),
        .item         (back_item),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .strided_addr (strided_addr),
        .linear_index (linear_index),
        .data_word    (data_word),
        .last         (m_tlast)
    );

    // Pack the result fields, lowest field first, zero pad to whole bytes.
    assign m_tdata = {2'b00, data_word, linear_index, strided_addr};

endmodule
